### rtl/core/scfr_pkg.sv
package scfr_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_HEAD  = 2'd0;
  localparam logic [1:0] CFG_PROTO = 2'd1;

  localparam logic [7:0] HEAD_RESET  = 8'd170;
  localparam logic [7:0] PROTO_RESET = 8'd1;

  // one parsed frame, handed from the parser to the checker
  typedef struct packed {
    logic [7:0]  address;
    logic [7:0]  command;
    logic [15:0] argument;
    logic        argument_valid;
    logic [5:0]  payload_count;
    logic [7:0]  sum;
    logic [7:0]  check;
  } frame_rec_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

### rtl/core/scfr_front.sv
module scfr_front #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  scfr_pkg::q_stat_t    q_stat,
  output logic                 q_push,
  output scfr_pkg::frame_rec_t q_data
);
  import scfr_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  localparam logic [3:0] PH_HEAD    = 4'd0;
  localparam logic [3:0] PH_ADDR    = 4'd1;
  localparam logic [3:0] PH_CTRL    = 4'd2;
  localparam logic [3:0] PH_LEN     = 4'd3;
  localparam logic [3:0] PH_PROTO   = 4'd4;
  localparam logic [3:0] PH_CMD     = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CHECK   = 4'd7;
  localparam logic [3:0] PH_TAIL    = 4'd8;

  logic [3:0]    phase;
  logic [7:0]    head_byte;
  logic [7:0]    protocol_byte;
  logic [7:0]    frame_length;
  logic [7:0]    bytes_seen;
  logic [CW-1:0] stored_count;
  logic [7:0]    running_sum;
  logic [7:0]    held_address;
  logic [7:0]    held_command;
  logic [15:0]   held_argument;

  logic          accept;
  logic [7:0]    bytes_seen_next;
  logic [7:0]    length_m1;
  logic          payload_done;
  logic [7:0]    count8;
  logic          arg_ok;

  assign accept          = push && !q_stat.full;
  assign bytes_seen_next = bytes_seen + 8'd1;
  assign length_m1       = frame_length - 8'd1;
  assign payload_done    = (frame_length == 8'd0) || (bytes_seen_next >= length_m1);
  assign count8          = 8'(stored_count);
  assign arg_ok          = stored_count >= CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte     <= HEAD_RESET;
      protocol_byte <= PROTO_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEAD:  head_byte     <= cfg_data;
        CFG_PROTO: protocol_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD;
    end else if (accept) begin
      case (phase)
        PH_HEAD: begin
          if (rx_byte == head_byte) phase <= PH_ADDR;
        end
        PH_ADDR: begin
          held_address <= rx_byte;
          phase        <= PH_CTRL;
        end
        PH_CTRL: begin
          running_sum <= rx_byte;
          phase       <= PH_LEN;
        end
        PH_LEN: begin
          frame_length  <= rx_byte;
          running_sum   <= running_sum + rx_byte;
          bytes_seen    <= 8'd0;
          stored_count  <= '0;
          held_argument <= 16'd0;
          phase         <= PH_PROTO;
        end
        PH_PROTO: begin
          if (rx_byte == protocol_byte) begin
            running_sum <= running_sum + rx_byte;
            phase       <= PH_CMD;
          end else begin
            phase <= PH_HEAD;
          end
        end
        PH_CMD: begin
          held_command <= rx_byte;
          running_sum  <= running_sum + rx_byte;
          phase        <= (frame_length == 8'd1) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          // overlong payload: keep counting, stop storing and summing
          if (stored_count < CW'(MAX_PAYLOAD)) begin
            if (!arg_ok) held_argument <= {held_argument[7:0], rx_byte};
            stored_count <= stored_count + CW'(1);
            running_sum  <= running_sum + rx_byte;
          end
          bytes_seen <= bytes_seen_next;
          if (payload_done) phase <= PH_CHECK;
        end
        PH_CHECK: begin
          phase <= PH_TAIL;
        end
        default: begin
          phase <= PH_HEAD;
        end
      endcase
    end
  end

  // every finished frame goes to the checker; mismatches are dropped there
  assign q_push                = accept && (phase == PH_CHECK);
  assign q_data.address        = held_address;
  assign q_data.command        = held_command;
  assign q_data.argument       = arg_ok ? held_argument : 16'd0;
  assign q_data.argument_valid = arg_ok;
  assign q_data.payload_count  = count8[5:0];
  assign q_data.sum            = running_sum;
  assign q_data.check          = rx_byte;

endmodule

### rtl/core/scfr_queue.sv
module scfr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  scfr_pkg::frame_rec_t wr_data,
  input  logic                 rd_en,
  output scfr_pkg::frame_rec_t rd_data,
  output scfr_pkg::q_stat_t    stat
);
  import scfr_pkg::*;

  frame_rec_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entry[wr_ptr] <= wr_data;
  end

  assign rd_data    = entry[rd_ptr];
  assign stat.full  = count == 2'd2;
  assign stat.valid = count != 2'd0;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("frame queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) && !rd_en |-> !wr_en)
    else $error("frame queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !rd_en)
    else $error("frame queue read while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("frame queue pointers disagree with count");
`endif

endmodule

### rtl/core/scfr_back.sv
module scfr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  scfr_pkg::q_stat_t    q_stat,
  input  scfr_pkg::frame_rec_t q_data,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           frame_address,
  output logic [7:0]           command,
  output logic [15:0]          argument,
  output logic                 argument_valid,
  output logic [5:0]           payload_count
);
  import scfr_pkg::*;

  logic out_valid;
  logic match;

  assign match = q_data.sum == q_data.check;
  // take the next frame whenever the output register is free or being drained
  assign q_pop = q_stat.valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= match;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && match) begin
      frame_address  <= q_data.address;
      command        <= q_data.command;
      argument       <= q_data.argument;
      argument_valid <= q_data.argument_valid;
      payload_count  <= q_data.payload_count;
    end
  end

  assign empty = !out_valid;

endmodule

### rtl/core/serial_command_frame_receiver.sv
// Serial command frame receiver.
// Input: one received byte per transaction on rx_byte, taken when push is high
// and full is low. Frames are head, address, control, length, protocol,
// command, payload, checksum, tail; head_byte and protocol_byte come from the
// config channel (cfg_index 0 and 1, cfg_ready is always high).
// Output: one result per frame whose additive checksum matches, held on the
// result ports while empty is low and retired by pop.
// Throughput: one byte per cycle while full is low. The parser keeps a running
// 8-bit sum, so the checksum needs no extra pass over the bytes.
// Path: with the output register free, a frame is written to the frame queue when
// its checksum byte is taken and then moved into the output register (empty low).
// Stalls: if pop stays low, finished frames pile up in the frame queue; when
// it holds two, full rises and input bytes wait.
// Reset (rst, synchronous): parser back to head search, queue and output
// register empty, head_byte = 170, protocol_byte = 1.
module serial_command_frame_receiver #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_address,
  output logic [7:0]  command,
  output logic [15:0] argument,
  output logic        argument_valid,
  output logic [5:0]  payload_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import scfr_pkg::*;

  q_stat_t    q_stat;
  frame_rec_t q_wr_data;
  frame_rec_t q_rd_data;
  logic       q_push;
  logic       q_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_stat.full;

  scfr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  scfr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  scfr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .q_data         (q_rd_data),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .frame_address  (frame_address),
    .command        (command),
    .argument       (argument),
    .argument_valid (argument_valid),
    .payload_count  (payload_count)
  );

endmodule
